// File: rtl/vpcrc_pkg.sv
package vpcrc_pkg;

   // Table geometry
   localparam int unsigned NUM_PARAMS = 128;
   localparam int unsigned IDX_W      = $clog2(NUM_PARAMS);

   // Field widths
   localparam int unsigned OPCODE_W = 2;
   localparam int unsigned INDEX_W  = 16;
   localparam int unsigned WORD_W   = 64;
   localparam int unsigned RANGE_W  = 32;
   localparam int unsigned UPD_W    = 48;
   localparam int unsigned CRC_W    = 32;
   localparam int unsigned STATUS_W = 2;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_UPDATE     = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_LOAD_PARAM = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_LOAD_RANGE = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_RECOMPUTE  = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BOUNDS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SAME   = 2'd3;

   // CRC and special index constants
   localparam logic [CRC_W-1:0]   CRC_POLY     = 32'hEDB8_8320;
   localparam logic [CRC_W-1:0]   CRC_INIT     = 32'hFFFF_FFFF;
   localparam logic [INDEX_W-1:0] COMMIT_INDEX = 16'hFFFF;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [INDEX_W-1:0]  entry_index;
      logic [WORD_W-1:0]   entry_value;
      logic [RANGE_W-1:0]  range_min;
      logic [RANGE_W-1:0]  range_max;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CRC_W-1:0]    table_crc;
      logic                write_request;
   } rsp_type;

   // Fold one byte into a reflected CRC-32, one bit per step
   function automatic logic [CRC_W-1:0] crc_byte_step(input logic [CRC_W-1:0] crc,
                                                      input logic [7:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {24'b0, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: rtl/validated_parameter_store_crc_core.sv
// Validated parameter store with CRC-32 guard.
// Requests enter on req_valid/req_stall with a req_type payload; every request
// yields exactly one response on rsp_valid/rsp_stall carrying status, the
// current table CRC and the sticky write-request flag.
// Loads, out-of-bounds requests and commit updates go from decode to done;
// an update rejected for range or as unchanged passes through check first.
// A stored update and a recompute run the CRC over the low 32 bits of
// every table word, one byte per cycle through a shared byte-step unit
// fed by the parameter RAM read port.
// One request is in work at a time; req_stall is high while it is in work and
// drops once the response is loaded, so the next request can be taken in the
// same cycle that the response appears.
// A finished response sits in the output register until the receiver drops
// rsp_stall; the next request may be accepted while it waits, but cannot
// finish before it is taken.
// Reset clears the table valid bits (all words and ranges read as zero), the
// CRC register, the write-request flag and all handshake state. No clearing
// pass is needed; the block accepts requests right after reset.
module validated_parameter_store_crc_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  vpcrc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vpcrc_pkg::rsp_type rsp_data
);

   import vpcrc_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_CHECK  = 6'b000100,
      S_FETCH  = 6'b001000,
      S_SHIFT  = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PARAMS - 1);

   state_type            state_ff, state_in;
   req_type              req_ff;
   logic [IDX_W-1:0]     ptr_ff, ptr_in;
   logic [1:0]           byte_cnt_ff, byte_cnt_in;
   logic [CRC_W-1:0]     crc_acc_ff, crc_acc_in;
   logic [CRC_W-1:0]     crc_word_ff, crc_word_in;
   logic                 pending_ff, pending_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [NUM_PARAMS-1:0] param_valid_ff;
   logic [NUM_PARAMS-1:0] range_valid_ff;
   logic                 pvalid_rd_ff;
   logic                 rvalid_rd_ff;

   logic                 req_accept;
   logic                 rsp_free;
   logic                 in_bounds;
   logic [IDX_W-1:0]     req_idx;

   // RAM controls
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic                 param_wr_en;
   logic [WORD_W-1:0]    param_wr_data;
   logic                 range_wr_en;
   logic [WORD_W-1:0]    param_rd_data;
   logic [2*RANGE_W-1:0] range_rd_data;

   // Datapath values
   logic [WORD_W-1:0]    cur_word;
   logic [RANGE_W-1:0]   cur_low;
   logic [RANGE_W-1:0]   cur_high;
   logic [UPD_W-1:0]     upd_value;
   logic                 out_of_range;
   logic                 unchanged;
   logic [RANGE_W-1:0]   crc_word_src;
   logic [RANGE_W-1:0]   shifted_word;
   logic [7:0]           crc_byte;
   logic [CRC_W-1:0]     crc_step;

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign in_bounds = req_ff.entry_index < INDEX_W'(NUM_PARAMS);
   assign req_idx   = req_ff.entry_index[IDX_W-1:0];

   // Read data, with never-written entries seen as zero
   assign cur_word     = pvalid_rd_ff ? param_rd_data : '0;
   assign cur_low      = rvalid_rd_ff ? range_rd_data[RANGE_W-1:0] : '0;
   assign cur_high     = rvalid_rd_ff ? range_rd_data[2*RANGE_W-1:RANGE_W] : '0;
   assign upd_value    = req_ff.entry_value[UPD_W-1:0];
   assign out_of_range = (upd_value < UPD_W'(cur_low)) || (upd_value > UPD_W'(cur_high));
   assign unchanged    = (cur_word == WORD_W'(upd_value));

   // Shared CRC byte-step unit
   assign crc_word_src = cur_word[RANGE_W-1:0];
   assign shifted_word = crc_word_src >> {byte_cnt_ff, 3'b000};
   assign crc_byte     = shifted_word[7:0];
   assign crc_step     = crc_byte_step(crc_acc_ff, crc_byte);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      byte_cnt_in   = byte_cnt_ff;
      crc_acc_in    = crc_acc_ff;
      crc_word_in   = crc_word_ff;
      pending_in    = pending_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rd_en         = 1'b0;
      rd_addr       = req_idx;
      param_wr_en   = 1'b0;
      param_wr_data = req_ff.entry_value;
      range_wr_en   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in = ST_OK;
            state_in  = S_DONE;
            unique case (req_ff.opcode)
               OP_UPDATE: begin
                  if (req_ff.entry_index == COMMIT_INDEX) begin
                     pending_in = 1'b1;
                  end else if (!in_bounds) begin
                     status_in = ST_BOUNDS;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = S_CHECK;
                  end
               end
               OP_LOAD_PARAM: begin
                  if (in_bounds) begin
                     param_wr_en = 1'b1;
                  end else begin
                     status_in = ST_BOUNDS;
                  end
               end
               OP_LOAD_RANGE: begin
                  if (in_bounds) begin
                     range_wr_en = 1'b1;
                  end else begin
                     status_in = ST_BOUNDS;
                  end
               end
               OP_RECOMPUTE: begin
                  pending_in = 1'b1;
                  ptr_in     = '0;
                  crc_acc_in = CRC_INIT;
                  state_in   = S_FETCH;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_CHECK: begin
            // Validate the update; if it passes, store it and start the sweep
            if (out_of_range) begin
               status_in = ST_RANGE;
               state_in  = S_DONE;
            end else if (unchanged) begin
               status_in = ST_SAME;
               state_in  = S_DONE;
            end else begin
               param_wr_en   = 1'b1;
               param_wr_data = WORD_W'(upd_value);
               ptr_in        = '0;
               crc_acc_in    = CRC_INIT;
               state_in      = S_FETCH;
            end
         end
         S_FETCH: begin
            rd_en       = 1'b1;
            rd_addr     = ptr_ff;
            byte_cnt_in = '0;
            state_in    = S_SHIFT;
         end
         S_SHIFT: begin
            // Fold one byte; on the last byte prefetch the next word, or finish after the last entry
            crc_acc_in  = crc_step;
            byte_cnt_in = byte_cnt_ff + 2'd1;
            if (byte_cnt_ff == 2'd3) begin
               if (ptr_ff == LAST_IDX) begin
                  crc_word_in = ~crc_step;
                  state_in    = S_DONE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_ff + IDX_W'(1);
                  ptr_in  = ptr_ff + IDX_W'(1);
               end
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = status_ff;
               rsp_data_in.table_crc     = crc_word_ff;
               rsp_data_in.write_request = pending_ff;
               state_in                  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         crc_word_ff  <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         crc_word_ff  <= crc_word_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_data;
      end
      ptr_ff      <= ptr_in;
      byte_cnt_ff <= byte_cnt_in;
      crc_acc_ff  <= crc_acc_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Entry valid bits: unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         param_valid_ff <= '0;
         range_valid_ff <= '0;
      end else begin
         if (param_wr_en) begin
            param_valid_ff[req_idx] <= 1'b1;
         end
         if (range_wr_en) begin
            range_valid_ff[req_idx] <= 1'b1;
         end
      end
   end

   // Valid bits follow the RAM read latency
   always_ff @(posedge clock) begin
      if (rd_en) begin
         pvalid_rd_ff <= param_valid_ff[rd_addr];
         rvalid_rd_ff <= range_valid_ff[rd_addr];
      end
   end

   vpcrc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_PARAMS)
   ) u_param_ram (
      .clock   (clock),
      .wr_en   (param_wr_en),
      .wr_addr (req_idx),
      .wr_data (param_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (param_rd_data)
   );

   vpcrc_ram #(
      .WIDTH (2 * RANGE_W),
      .DEPTH (NUM_PARAMS)
   ) u_range_ram (
      .clock   (clock),
      .wr_en   (range_wr_en),
      .wr_addr (req_idx),
      .wr_data ({req_ff.range_max, req_ff.range_min}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (range_rd_data)
   );

endmodule

// File: rtl/vpcrc_ram.sv
module vpcrc_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/vpcrc_checker.sv
module vpcrc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input vpcrc_pkg::rsp_type rsp_data
);

   import vpcrc_pkg::*;

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Block takes one request at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another is in work");

   // Write request is sticky
   a_wr_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.write_request |=> !rsp_valid || rsp_data.write_request)
      else $error("write request flag dropped");

   // Reset drops the response
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind validated_parameter_store_crc_core vpcrc_checker u_checker (.*);
